>>> src/fpr_pkg.sv
`default_nettype none
package fpr_pkg;
   localparam int OpenPacketsDefault = 8;
   localparam int MaxWordsDefault    = 16;

   localparam logic [1:0] FLIT_HEAD = 2'd0;
   localparam logic [1:0] FLIT_BODY = 2'd1;
   localparam logic [1:0] FLIT_TAIL = 2'd2;

   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_HEAD_OPEN = 3'd1;
   localparam logic [2:0] EV_BODY_OK   = 3'd2;
   localparam logic [2:0] EV_BODY_DROP = 3'd3;
   localparam logic [2:0] EV_HEAD_FULL = 3'd4;
   localparam logic [2:0] EV_DONE      = 3'd5;
   localparam logic [2:0] EV_TAIL_MISS = 3'd6;
   localparam logic [2:0] EV_WORD      = 3'd7;

   // input flit fields, kind in the lowest bits
   typedef struct packed {
      logic [7:0]  req_size_in;
      logic        read_flag_in;
      logic [31:0] word_in;
      logic [31:0] time_stamp;
      logic [2:0]  channel_id;
      logic [7:0]  dest_node;
      logic [7:0]  source_node;
      logic [15:0] pkt_id;
      logic        req_level;
      logic [1:0]  kind;
   } flit_fields_type;

   // controller commands to the datapath
   typedef struct packed {
      logic capture;   // register incoming flit
      logic search;    // step the id search
      logic search_go; // start search from slot 0
      logic do_head;
      logic do_body;
      logic shift;     // one compaction step
      logic shift_go;  // start compaction at matched slot
      logic rd_go;     // start word readout
      logic rd_step;   // advance word readout
   } fpr_cmd_type;

   // datapath status to the controller
   typedef struct packed {
      logic       changed;   // captured level differs from stored
      logic [1:0] ftype;
      logic       full;
      logic       search_done;
      logic       found;
      logic       words_full;
      logic       shift_done;
      logic       no_words;
      logic       rd_last;
   } fpr_stat_type;
endpackage
`default_nettype wire

>>> src/fpr_datapath.sv
`default_nettype none
module fpr_datapath #(
   parameter int OPEN_PACKETS = fpr_pkg::OpenPacketsDefault,
   parameter int MAX_WORDS    = fpr_pkg::MaxWordsDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fpr_pkg::flit_fields_type flit,
   input  wire fpr_pkg::fpr_cmd_type cmd,
   output fpr_pkg::fpr_stat_type     stat,
   output logic                      ack_level,
   output logic [34:0]               hdr_q,
   output logic [31:0]               time_q,
   output logic [3:0]                word_index,
   output logic [40:0]               word_q
);
   import fpr_pkg::*;

   localparam int SW = (OPEN_PACKETS > 1) ? $clog2(OPEN_PACKETS) : 1;
   localparam int CW = $clog2(OPEN_PACKETS + 1);
   localparam int WW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int NW = $clog2(MAX_WORDS + 1);
   localparam int AW = SW + WW;
   localparam int DEPTH = OPEN_PACKETS * (2 ** WW);

   logic                 level_ff;
   logic                 changed_ff;
   logic [CW-1:0]        count_ff;
   flit_fields_type      flit_ff;
   logic [SW-1:0]        slot_ff;
   logic [CW-1:0]        scan_ff;
   logic                 found_ff;
   logic [NW-1:0]        rd_ff;
   logic [NW-1:0]        nwords_ff;
   logic [34:0]          hdr_mem [OPEN_PACKETS];
   logic [31:0]          time_mem [OPEN_PACKETS];
   logic [NW-1:0]        cnt_mem [OPEN_PACKETS];
   logic [40:0]          pay_mem [DEPTH];
   logic [40:0]          pay_rd_ff;
   logic [SW-1:0]        row_map_ff [OPEN_PACKETS];
   logic [SW-1:0]        row_done_ff;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [40:0]          wr_data;
   logic [SW-1:0]        scan_idx;
   logic [SW-1:0]        scan_nx;
   logic                 shift_more;

   assign scan_idx = scan_ff[SW-1:0];
   assign scan_nx  = SW'(scan_ff + CW'(1));

   // status to controller
   always_comb begin
      stat.changed     = changed_ff;
      stat.ftype       = flit_ff.kind;
      stat.full        = count_ff >= CW'(OPEN_PACKETS);
      stat.search_done = found_ff || (scan_ff >= count_ff);
      stat.found       = found_ff;
      stat.words_full  = cnt_mem[slot_ff] >= NW'(MAX_WORDS);
      // count is already reduced here, so slots below it still take a copy
      shift_more       = scan_ff < count_ff;
      stat.shift_done  = !shift_more;
      stat.no_words    = nwords_ff == '0;
      stat.rd_last     = rd_ff + NW'(1) >= nwords_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
         count_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         if (cmd.capture && (flit.req_level != level_ff)) level_ff <= ~level_ff;
         if (cmd.search_go) found_ff <= 1'b0;
         else if (cmd.search && !found_ff && scan_ff < count_ff &&
                  hdr_mem[scan_idx][34:19] == flit_ff.pkt_id)
            found_ff <= 1'b1;
         if (cmd.do_head) count_ff <= count_ff + CW'(1);
         if (cmd.shift_go) count_ff <= count_ff - CW'(1);
      end
   end

   // flit capture, search pointer, header table
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         flit_ff    <= flit;
         changed_ff <= flit.req_level != level_ff;
      end
      if (cmd.search_go) scan_ff <= '0;
      else if (cmd.search && !found_ff && scan_ff < count_ff) begin
         if (hdr_mem[scan_idx][34:19] == flit_ff.pkt_id) slot_ff <= scan_idx;
         else scan_ff <= scan_ff + CW'(1);
      end else if (cmd.shift_go) scan_ff <= CW'(slot_ff);
      else if (cmd.shift) begin
         if (shift_more) begin
            hdr_mem[scan_idx]  <= hdr_mem[scan_nx];
            time_mem[scan_idx] <= time_mem[scan_nx];
            cnt_mem[scan_idx]  <= cnt_mem[scan_nx];
         end
         scan_ff <= scan_ff + CW'(1);
      end
      if (cmd.do_head) begin
         hdr_mem[count_ff[SW-1:0]]  <= {flit_ff.pkt_id, flit_ff.source_node,
                                        flit_ff.dest_node, flit_ff.channel_id};
         time_mem[count_ff[SW-1:0]] <= flit_ff.time_stamp;
         cnt_mem[count_ff[SW-1:0]]  <= '0;
      end
      if (cmd.do_body) cnt_mem[slot_ff] <= cnt_mem[slot_ff] + NW'(1);
      if (cmd.shift_go) begin
         hdr_q       <= hdr_mem[slot_ff];
         time_q      <= time_mem[slot_ff];
         nwords_ff   <= cnt_mem[slot_ff];
         row_done_ff <= row_map_ff[slot_ff];
         rd_ff       <= '0;
      end else if (cmd.rd_step) rd_ff <= rd_ff + NW'(1);
   end

   // payload row of each open slot; rows rotate with compaction, freed row goes last
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < OPEN_PACKETS; i++) row_map_ff[i] <= SW'(i);
      end else if (cmd.shift) begin
         if (shift_more) row_map_ff[scan_idx] <= row_map_ff[scan_nx];
         else row_map_ff[scan_idx] <= row_done_ff;
      end
   end

   // payload memory: one write port for body flits
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {row_map_ff[slot_ff], cnt_mem[slot_ff][WW-1:0]};
      wr_data = {flit_ff.word_in, flit_ff.read_flag_in, flit_ff.req_size_in};
      if (cmd.do_body) wr_en = 1'b1;
      rd_addr = {row_done_ff, rd_ff[WW-1:0]};
   end

   // read port doubles as the readout port
   always_ff @(posedge clock) begin
      if (wr_en) pay_mem[wr_addr] <= wr_data;
      pay_rd_ff <= pay_mem[rd_addr];
   end

   assign word_q     = pay_rd_ff;
   assign word_index = 4'(rd_ff);
   assign ack_level  = level_ff;
endmodule
`default_nettype wire

>>> src/fpr_controller.sv
`default_nettype none
module fpr_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [2:0]                event_res,
   output logic                      out_last,
   output fpr_pkg::fpr_cmd_type      cmd,
   input  wire fpr_pkg::fpr_stat_type stat
);
   import fpr_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_FETCH  = 3'd4;
   localparam logic [2:0] S_OUT    = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [2:0] ev_ff, ev_in;
   logic       last_ff, last_in;
   logic       word_ff, word_in;

   assign in_ready  = state_ff == S_IDLE;
   assign out_valid = state_ff == S_OUT;
   assign event_res = ev_ff;
   assign out_last  = last_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ev_in    = ev_ff;
      last_in  = last_ff;
      word_in  = word_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.capture = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            last_in = 1'b1;
            word_in = 1'b0;
            cmd.search_go = 1'b1;
            state_in = S_OUT;
            if (!stat.changed) ev_in = EV_NONE;
            else if (stat.ftype == FLIT_HEAD) begin
               if (stat.full) ev_in = EV_HEAD_FULL;
               else begin
                  ev_in = EV_HEAD_OPEN;
                  cmd.do_head = 1'b1;
               end
            end else if (stat.ftype == FLIT_BODY || stat.ftype == FLIT_TAIL)
               state_in = S_SEARCH;
            else ev_in = EV_NONE;
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            if (stat.search_done) begin
               cmd.search = 1'b0;
               state_in = S_OUT;
               if (stat.ftype == FLIT_BODY) begin
                  if (!stat.found || stat.words_full) ev_in = EV_BODY_DROP;
                  else begin
                     ev_in = EV_BODY_OK;
                     cmd.do_body = 1'b1;
                  end
               end else if (!stat.found) ev_in = EV_TAIL_MISS;
               else begin
                  cmd.shift_go = 1'b1;
                  ev_in = EV_DONE;
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_done) state_in = S_FETCH;
         end
         S_FETCH: begin
            last_in  = stat.no_words;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_ready) begin
               if (last_ff) state_in = S_IDLE;
               else begin
                  if (word_ff) cmd.rd_step = 1'b1;
                  ev_in    = EV_WORD;
                  word_in  = 1'b1;
                  last_in  = word_ff ? 1'b0 : 1'b0;
                  state_in = S_FETCH;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_FETCH && word_ff) last_in = stat.rd_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         word_ff  <= 1'b0;
         last_ff  <= 1'b1;
         ev_ff    <= EV_NONE;
      end else begin
         state_ff <= state_in;
         word_ff  <= word_in;
         last_ff  <= last_in;
         ev_ff    <= ev_in;
      end
   end
endmodule
`default_nettype wire

>>> src/flit_packet_reassembly_unit.sv
// sequence: idle, head and unknown flits go through decode straight to their result;
// a body or tail flit first searches the open slots in order, stopping at a match or the end
// a completing tail compacts the table before its done result; each word is fetched, then output
// flow: one flit at a time; the next flit is taken the cycle after the last result
// reset: synchronous active high; clears the level, open count, row map and controller state
`default_nettype none
module flit_packet_reassembly_unit #(
   parameter int OPEN_PACKETS = fpr_pkg::OpenPacketsDefault,
   parameter int MAX_WORDS    = fpr_pkg::MaxWordsDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // req_level, packet id, source_node, dest_node, channel_id,
   // time_stamp, word_in, read_flag_in, req_size_in, zero pad
   input  wire logic [111:0] req_tdata,
   input  wire logic [1:0]   req_tuser,   // flit kind
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // ack_level, done_packet_id, done_source, done_dest, done_channel,
   // done_time, word_index, word_out, read_flag_out, req_size_out, zero pad
   output logic [119:0]      rsp_tdata,
   output logic [2:0]        rsp_tuser,   // event_res
   output logic              rsp_tlast
);
   import fpr_pkg::*;

   flit_fields_type flit;
   fpr_cmd_type     cmd;
   fpr_stat_type    stat;
   logic            ack_level;
   logic [34:0]     hdr_q;
   logic [31:0]     time_q;
   logic [3:0]      word_index;
   logic [40:0]     word_q;
   logic [2:0]      event_res;
   logic            is_pkt;
   logic [34:0]     hdr_o;
   logic [31:0]     time_o;
   logic [3:0]      idx_o;
   logic [40:0]     word_o;

   assign flit = flit_fields_type'({req_tdata[108:0], req_tuser});

   fpr_controller u_ctrl (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .event_res, .out_last(rsp_tlast), .cmd, .stat
   );

   fpr_datapath #(.OPEN_PACKETS(OPEN_PACKETS), .MAX_WORDS(MAX_WORDS)) u_dp (
      .clock, .reset, .flit, .cmd, .stat, .ack_level,
      .hdr_q, .time_q, .word_index, .word_q
   );

   // zero the fields that do not apply to the event
   always_comb begin
      is_pkt = event_res == EV_DONE || event_res == EV_WORD;
      hdr_o  = is_pkt ? hdr_q : '0;
      time_o = is_pkt ? time_q : '0;
      idx_o  = (event_res == EV_WORD) ? word_index : '0;
      word_o = (event_res == EV_WORD) ? word_q : '0;
   end

   assign rsp_tdata = {7'd0, word_o[7:0], word_o[8], word_o[40:9], idx_o, time_o,
                       hdr_o[2:0], hdr_o[10:3], hdr_o[18:11], hdr_o[34:19],
                       ack_level};
   assign rsp_tuser = event_res;
endmodule
`default_nettype wire

>>> tb/tb.sv
`default_nettype none
module tb;
   import fpr_pkg::*;

   localparam int NSLOT = OpenPacketsDefault;
   localparam int NWORD = MaxWordsDefault;
   localparam int WATCH_LIMIT = 20000;

   // expected result fields
   typedef struct packed {
      logic        last;
      logic [7:0]  size;
      logic        rd;
      logic [31:0] word;
      logic [3:0]  idx;
      logic [31:0] tm;
      logic [2:0]  ch;
      logic [7:0]  dst;
      logic [7:0]  src;
      logic [15:0] id;
      logic [2:0]  ev;
      logic        ack;
   } rsp_fields_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [111:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic rsp_tlast;

   flit_packet_reassembly_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state: open packet table kept in insertion order
   logic        lvl;
   int          n_open;
   logic [15:0] t_id[NSLOT];
   logic [7:0]  t_src[NSLOT], t_dst[NSLOT];
   logic [2:0]  t_ch[NSLOT];
   logic [31:0] t_tm[NSLOT];
   int          t_cnt[NSLOT];
   logic [40:0] t_words[NSLOT][NWORD];

   rsp_fields_type pending_rsp[$];
   int errors = 0;
   int watch = 0;
   int rsp_hold = 0;
   bit quiet = 0;

   task automatic report(input string what, input rsp_fields_type got,
                         input rsp_fields_type want);
      $display("mismatch %s: got %p want %p", what, got, want);
      errors++;
   endtask

   function automatic void expect_rsp(input rsp_fields_type r);
      pending_rsp = {pending_rsp, r};
   endfunction

   function automatic rsp_fields_type plain(input logic [2:0] ev);
      rsp_fields_type r;
      r = '0;
      r.ack = lvl;
      r.ev = ev;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic int find_oldest(input logic [15:0] id);
      for (int i = 0; i < n_open; i++)
         if (t_id[i] == id) return i;
      return -1;
   endfunction

   // works out the results of one flit and updates the table
   task automatic reassemble(input flit_fields_type f);
      int m;
      int n;
      rsp_fields_type r;
      if (f.req_level == lvl) begin
         expect_rsp(plain(EV_NONE));
         return;
      end
      lvl = ~lvl;
      case (f.kind)
         FLIT_HEAD: begin
            if (n_open >= NSLOT) begin
               expect_rsp(plain(EV_HEAD_FULL));
            end else begin
               t_id[n_open] = f.pkt_id;
               t_src[n_open] = f.source_node;
               t_dst[n_open] = f.dest_node;
               t_ch[n_open] = f.channel_id;
               t_tm[n_open] = f.time_stamp;
               t_cnt[n_open] = 0;
               n_open++;
               expect_rsp(plain(EV_HEAD_OPEN));
            end
         end
         FLIT_BODY: begin
            m = find_oldest(f.pkt_id);
            if (m < 0 || t_cnt[m] >= NWORD) begin
               expect_rsp(plain(EV_BODY_DROP));
            end else begin
               t_words[m][t_cnt[m]] = {f.word_in, f.read_flag_in, f.req_size_in};
               t_cnt[m]++;
               expect_rsp(plain(EV_BODY_OK));
            end
         end
         FLIT_TAIL: begin
            m = find_oldest(f.pkt_id);
            if (m < 0) begin
               expect_rsp(plain(EV_TAIL_MISS));
            end else begin
               n = t_cnt[m];
               r = plain(EV_DONE);
               r.id = t_id[m];
               r.src = t_src[m];
               r.dst = t_dst[m];
               r.ch = t_ch[m];
               r.tm = t_tm[m];
               r.last = (n == 0);
               expect_rsp(r);
               for (int i = 0; i < n; i++) begin
                  r.ev = EV_WORD;
                  r.idx = i[3:0];
                  r.word = t_words[m][i][40:9];
                  r.rd = t_words[m][i][8];
                  r.size = t_words[m][i][7:0];
                  r.last = (i == n - 1);
                  expect_rsp(r);
               end
               for (int i = m; i + 1 < n_open; i++) begin
                  t_id[i] = t_id[i+1];
                  t_src[i] = t_src[i+1];
                  t_dst[i] = t_dst[i+1];
                  t_ch[i] = t_ch[i+1];
                  t_tm[i] = t_tm[i+1];
                  t_cnt[i] = t_cnt[i+1];
                  t_words[i] = t_words[i+1];
               end
               n_open--;
            end
         end
         default: expect_rsp(plain(EV_NONE));
      endcase
   endtask

   // sends one flit, with an optional idle burst in front
   task automatic send_flit(input flit_fields_type f);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, f[110:2]};
      req_tuser <= f.kind;
      reassemble(f);
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic flit_fields_type rand_flit(input logic [1:0] ft, input logic [15:0] id);
      flit_fields_type f;
      f.req_level = ~lvl;
      f.kind = ft;
      f.pkt_id = id;
      f.source_node = 8'($urandom);
      f.dest_node = 8'($urandom);
      f.channel_id = 3'($urandom);
      f.time_stamp = $urandom;
      f.word_in = $urandom;
      f.read_flag_in = 1'($urandom);
      f.req_size_in = 8'($urandom);
      return f;
   endfunction

   // result checking and receiver stalls
   always @(posedge clock) begin
      rsp_fields_type got;
      rsp_fields_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ack  = rsp_tdata[0];
         got.id   = rsp_tdata[16:1];
         got.src  = rsp_tdata[24:17];
         got.dst  = rsp_tdata[32:25];
         got.ch   = rsp_tdata[35:33];
         got.tm   = rsp_tdata[67:36];
         got.idx  = rsp_tdata[71:68];
         got.word = rsp_tdata[103:72];
         got.rd   = rsp_tdata[104];
         got.size = rsp_tdata[112:105];
         got.ev   = rsp_tuser;
         got.last = rsp_tlast;
         if (pending_rsp.size() == 0) begin
            report("unexpected result", got, '0);
         end else begin
            want = pending_rsp.pop_front();
            if (got != want) report("result", got, want);
         end
      end
      if (quiet) rsp_tready <= 1'b1;
      else if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= int'($urandom_range(0, 17));
      end else rsp_tready <= 1'b1;
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) watch <= 0;
      else watch <= watch + 1;
      if (watch >= WATCH_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // extremes, every flit kind and each drop case
   task automatic test_directed;
      flit_fields_type f;
      f = rand_flit(FLIT_HEAD, 16'h0000);
      f.req_level = lvl;
      send_flit(f);                                   // idle sample
      f = rand_flit(FLIT_HEAD, 16'hffff);
      f.source_node = 8'hff; f.dest_node = 8'hff; f.channel_id = 3'h7;
      f.time_stamp = 32'hffffffff;
      send_flit(f);
      f = rand_flit(FLIT_BODY, 16'hffff);
      f.word_in = 32'hffffffff; f.read_flag_in = 1'b1; f.req_size_in = 8'hff;
      send_flit(f);
      f = rand_flit(FLIT_BODY, 16'hffff);
      f.word_in = 32'h0; f.read_flag_in = 1'b0; f.req_size_in = 8'h0;
      send_flit(f);
      send_flit(rand_flit(FLIT_BODY, 16'h1234));     // unmatched body
      send_flit(rand_flit(FLIT_TAIL, 16'h1234));     // unmatched tail
      send_flit(rand_flit(2'd3, 16'h0));             // unknown kind
      send_flit(rand_flit(FLIT_TAIL, 16'hffff));
      // duplicate ids, then fill the table
      for (int i = 0; i < NSLOT + 1; i++)
         send_flit(rand_flit(FLIT_HEAD, i < 2 ? 16'h5 : 16'(i)));
      for (int i = 0; i < NWORD + 1; i++) send_flit(rand_flit(FLIT_BODY, 16'h5)); // overflow
      send_flit(rand_flit(FLIT_TAIL, 16'h5));
      send_flit(rand_flit(FLIT_TAIL, 16'h5));        // empty packet
      for (int i = 2; i < NSLOT; i++) send_flit(rand_flit(FLIT_TAIL, 16'(i)));
   endtask

   // random head, body and tail flits over a small id pool, plus noise
   task automatic test_random(input int count);
      flit_fields_type f;
      int k;
      logic [15:0] id;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 99);
         id = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 11));
         if (k < 30) f = rand_flit(FLIT_HEAD, id);
         else if (k < 70) f = rand_flit(FLIT_BODY, id);
         else if (k < 90) f = rand_flit(FLIT_TAIL, id);
         else if (k < 95) f = rand_flit(2'd3, id);
         else begin
            f = rand_flit(2'($urandom), id);
            f.req_level = lvl;
         end
         send_flit(f);
      end
   endtask

   // hold off until every expected result has come, then send 20 random flits
   task automatic test_pause;
      drain();
      test_random(20);
   endtask

   initial begin
      lvl = 1'b0;
      n_open = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(150);
      test_pause();
      quiet = 1;
      test_random(100);
      drain();
      repeat (100) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> filelist.f
src/fpr_pkg.sv
src/fpr_datapath.sv
src/fpr_controller.sv
src/flit_packet_reassembly_unit.sv
tb/tb.sv
